// ===== src/aihp_pkg.sv =====
package aihp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_LEVEL   = 4'd1,
    PH_ZERO    = 4'd2,
    PH_VERSION = 4'd3,
    PH_MAP     = 4'd4,
    PH_DEVID   = 4'd5,
    PH_DATE    = 4'd6,
    PH_TIME    = 4'd7,
    PH_PNAME   = 4'd8,
    PH_PVER    = 4'd9,
    PH_XLEN    = 4'd10,
    PH_XDATA   = 4'd11,
    PH_TRAIL   = 4'd12,
    PH_DONE    = 4'd13,
    PH_BAD     = 4'd14,
    PH_NONE    = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_SHORT  = 2'd1,
    ST_BAD_FORMAT = 2'd2
  } status_e;

  localparam logic [2:0] FID_DEVID = 3'd0;
  localparam logic [2:0] FID_DATE  = 3'd1;
  localparam logic [2:0] FID_TIME  = 3'd2;
  localparam logic [2:0] FID_PNAME = 3'd3;
  localparam logic [2:0] FID_PVER  = 3'd4;
  localparam logic [2:0] FID_XDATA = 3'd5;

  localparam logic [7:0] MAGIC_LEN     = 8'd5;
  localparam logic [7:0] CHAR_SHORT    = 8'h32;  // '2'
  localparam logic [7:0] CHAR_LONG     = 8'h67;  // 'g'
  localparam logic [7:0] CHAR_DOT      = 8'h2E;
  localparam logic [7:0] CHAR_ONE      = 8'h31;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] VERSION_MIN   = 8'd1;
  localparam logic [7:0] VERSION_MAX   = 8'd3;
  localparam logic [7:0] MAP_V3        = 8'h1F;
  localparam logic [3:0] LEVEL_UNDEF   = 4'd10;
  localparam logic [8:0] POS_MAX       = 9'h1FF;
  localparam logic [8:0] MIN_BLOCK_POS = 9'd8;

  typedef struct packed {
    logic       byte_valid;
    logic [2:0] field_id;
    logic [7:0] field_offset;
    logic [7:0] field_byte;
    logic       done_res;
    status_e    status;
    logic [7:0] block_version;
    logic [7:0] content_map;
    logic [3:0] info_level;
  } result_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h4C;  // 'L'
      3'd1:    c = 8'h78;  // 'x'
      3'd2:    c = 8'h5F;  // '_'
      3'd3:    c = 8'h3F;  // '?'
      3'd4:    c = 8'h7A;  // 'z'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // rows: field id, columns: version - 1
  function automatic logic [7:0] field_len(input logic [2:0] fid, input logic [1:0] vidx);
    logic [7:0] n;
    case ({fid, vidx})
      {FID_DEVID, 2'd0}: n = 8'd16;
      {FID_DEVID, 2'd1}: n = 8'd17;
      {FID_DEVID, 2'd2}: n = 8'd29;
      {FID_DATE,  2'd0}: n = 8'd11;
      {FID_DATE,  2'd1}: n = 8'd12;
      {FID_DATE,  2'd2}: n = 8'd12;
      {FID_TIME,  2'd0}: n = 8'd8;
      {FID_TIME,  2'd1}: n = 8'd9;
      {FID_TIME,  2'd2}: n = 8'd9;
      {FID_PNAME, 2'd0}: n = 8'd15;
      {FID_PNAME, 2'd1}: n = 8'd16;
      {FID_PNAME, 2'd2}: n = 8'd33;
      {FID_PVER,  2'd0}: n = 8'd10;
      {FID_PVER,  2'd1}: n = 8'd11;
      {FID_PVER,  2'd2}: n = 8'd17;
      default:           n = 8'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== src/aihp_if.sv =====
interface aihp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface aihp_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [2:0] field_id;
  logic [7:0] field_offset;
  logic [7:0] field_byte;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] block_version;
  logic [7:0] content_map;
  logic [3:0] info_level;

  modport source(output valid, output byte_valid, output field_id, output field_offset,
                 output field_byte, output done_res, output status, output block_version,
                 output content_map, output info_level, input ready);
  modport sink(input valid, input byte_valid, input field_id, input field_offset,
               input field_byte, input done_res, input status, input block_version,
               input content_map, input info_level, output ready);
endinterface

// ===== src/aihp_parser.sv =====
module aihp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              res_valid_o,
  output aihp_pkg::result_t res_o
);
  import aihp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [8:0] pos_q, pos_d;
  logic [7:0] off_q, off_d;
  logic       long_q, long_d;
  logic       bad_q, bad_d;
  logic [7:0] version_q, version_d;
  logic [7:0] map_q, map_d;
  logic [3:0] level_q, level_d;
  logic [7:0] xlen_q, xlen_d;
  logic       complete_q, complete_d;

  logic       emit;
  logic [2:0] fid;
  logic [7:0] off_inc;
  logic [3:0] next_start;
  phase_e     first_from_map;
  phase_e     first_from_next;
  status_e    status;

  function automatic logic present(input logic [3:0] ph, input logic [7:0] m);
    logic r;
    case (ph)
      PH_DEVID:          r = m[0];
      PH_DATE, PH_TIME:  r = m[1];
      PH_PNAME:          r = m[2];
      PH_PVER:           r = m[2] & m[3];
      PH_XLEN:           r = m[4];
      default:           r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic phase_e first_field(input logic [3:0] start, input logic [7:0] m);
    phase_e r;
    r = PH_NONE;
    for (int p = PH_XLEN; p >= PH_DEVID; p--) begin
      if (4'(p) >= start && present(4'(p), m)) begin
        r = phase_e'(4'(p));
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] level_code(input logic [7:0] c);
    logic [7:0] diff;
    logic [3:0] r;
    diff = c - CHAR_ZERO;
    if (c == CHAR_DOT) begin
      r = 4'd0;
    end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
      r = diff[3:0];
    end else begin
      r = LEVEL_UNDEF;
    end
    return r;
  endfunction

  assign fid        = 3'(phase_q - PH_DEVID);
  assign off_inc    = off_q + 8'd1;
  assign next_start = phase_q + 4'd1;

  always_comb begin
    first_from_map  = first_field(PH_DEVID, (phase_q == PH_MAP) ? data_byte_i : MAP_V3);
    first_from_next = first_field(next_start, map_q);
  end

  always_comb begin
    phase_d    = phase_q;
    off_d      = off_q;
    long_d     = long_q;
    bad_d      = bad_q;
    version_d  = version_q;
    map_d      = map_q;
    level_d    = level_q;
    xlen_d     = xlen_q;
    complete_d = complete_q;
    emit       = 1'b0;
    case (phase_q)
      PH_MAGIC: begin
        if (pos_q < 9'(MAGIC_LEN)) begin
          if (data_byte_i != magic_char(pos_q[2:0])) bad_d = 1'b1;
        end else begin
          if (data_byte_i == CHAR_SHORT) begin
            long_d = 1'b0;
          end else if (data_byte_i == CHAR_LONG) begin
            long_d = 1'b1;
          end else begin
            bad_d = 1'b1;
          end
          phase_d = PH_LEVEL;
        end
      end
      PH_LEVEL: begin
        level_d = level_code(data_byte_i);
        if (long_q) begin
          phase_d = PH_ZERO;
        end else begin
          phase_d = bad_q ? PH_BAD : PH_VERSION;
        end
      end
      PH_ZERO: begin
        bad_d   = bad_q | (data_byte_i != 8'd0);
        phase_d = bad_d ? PH_BAD : PH_VERSION;
      end
      PH_VERSION: begin
        version_d = data_byte_i;
        if (data_byte_i < VERSION_MIN || data_byte_i > VERSION_MAX) begin
          phase_d = PH_BAD;
        end else if (data_byte_i == VERSION_MAX) begin
          map_d = MAP_V3;
        end else begin
          phase_d = PH_MAP;
        end
      end
      PH_MAP: begin
        map_d = data_byte_i;
      end
      PH_DEVID, PH_DATE, PH_TIME, PH_PNAME, PH_PVER: begin
        emit  = 1'b1;
        off_d = off_inc;
        if (off_inc >= field_len(fid, 2'(version_q - 8'd1))) begin
          phase_d = (first_from_next == PH_NONE) ? PH_TRAIL : first_from_next;
          off_d   = 8'd0;
        end
      end
      PH_XLEN: begin
        xlen_d  = data_byte_i;
        off_d   = 8'd0;
        phase_d = (data_byte_i == 8'd0) ? PH_TRAIL : PH_XDATA;
      end
      PH_XDATA: begin
        emit  = 1'b1;
        off_d = off_inc;
        if (off_inc >= xlen_q) begin
          complete_d = 1'b1;
          phase_d    = PH_DONE;
        end
      end
      PH_TRAIL: begin
        complete_d = 1'b1;
        phase_d    = PH_DONE;
      end
      default: ;
    endcase
    // entering the field section after the map (or an implied map)
    if ((phase_q == PH_MAP) ||
        (phase_q == PH_VERSION && data_byte_i == VERSION_MAX)) begin
      off_d = 8'd0;
      if (first_from_map == PH_NONE) begin
        complete_d = 1'b1;
        phase_d    = PH_DONE;
      end else begin
        phase_d = first_from_map;
      end
    end
  end

  always_comb begin
    if (pos_q < MIN_BLOCK_POS) begin
      status = ST_TOO_SHORT;
    end else if (bad_d || phase_d == PH_BAD) begin
      status = ST_BAD_FORMAT;
    end else if (complete_d) begin
      status = ST_OK;
    end else begin
      status = ST_TOO_SHORT;
    end
  end

  always_comb begin
    res_valid_o         = emit | last_byte_i;
    res_o               = '0;
    res_o.status        = ST_OK;
    if (emit) begin
      res_o.byte_valid   = 1'b1;
      res_o.field_id     = (phase_q == PH_XDATA) ? FID_XDATA : fid;
      res_o.field_offset = off_q;
      res_o.field_byte   = data_byte_i;
    end
    if (last_byte_i) begin
      res_o.done_res      = 1'b1;
      res_o.status        = status;
      res_o.block_version = version_d;
      res_o.content_map   = map_d;
      res_o.info_level    = level_d;
    end
  end

  assign pos_d = (pos_q != POS_MAX) ? pos_q + 9'd1 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      pos_q      <= '0;
      off_q      <= '0;
      long_q     <= 1'b0;
      bad_q      <= 1'b0;
      version_q  <= '0;
      map_q      <= '0;
      level_q    <= '0;
      xlen_q     <= '0;
      complete_q <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q    <= PH_MAGIC;
        pos_q      <= '0;
        off_q      <= '0;
        long_q     <= 1'b0;
        bad_q      <= 1'b0;
        version_q  <= '0;
        map_q      <= '0;
        level_q    <= '0;
        xlen_q     <= '0;
        complete_q <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        off_q      <= off_d;
        long_q     <= long_d;
        bad_q      <= bad_d;
        version_q  <= version_d;
        map_q      <= map_d;
        level_q    <= level_d;
        xlen_q     <= xlen_d;
        complete_q <= complete_d;
      end
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> phase_q == PH_MAGIC && pos_q == 9'd0 && !bad_q)
    else $error("parser did not restart after last byte");

  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && emit |-> phase_q == PH_DEVID || phase_q == PH_DATE || phase_q == PH_TIME ||
                         phase_q == PH_PNAME || phase_q == PH_PVER || phase_q == PH_XDATA)
    else $error("payload byte emitted outside a field");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i && res_o.status == ST_OK |-> pos_q >= MIN_BLOCK_POS && complete_d)
    else $error("ok status on short or unfinished block");

endmodule

// ===== src/app_info_header_parser_unit.sv =====
// Output: a result transaction appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parse state advances in the accepting cycle,
//   and a new byte is taken in the same cycle the held result is taken; a stalled
//   result holds off input.
// Reset: rst_ni asynchronous, active low; clears the parse state to the magic phase
//   and empties the output register. The parser also restarts after each last byte.
module app_info_header_parser_unit (
  input  logic clk_i,
  input  logic rst_ni,
  aihp_in_if.sink    in_i,
  aihp_out_if.source out_o
);
  import aihp_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_valid_q;
  result_t res_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  aihp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.byte_valid    = res_q.byte_valid;
  assign out_o.field_id      = res_q.field_id;
  assign out_o.field_offset  = res_q.field_offset;
  assign out_o.field_byte    = res_q.field_byte;
  assign out_o.done_res      = res_q.done_res;
  assign out_o.status        = res_q.status;
  assign out_o.block_version = res_q.block_version;
  assign out_o.content_map   = res_q.content_map;
  assign out_o.info_level    = res_q.info_level;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !out_valid_q || out_o.ready)
    else $error("input taken while result transaction stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.ready && !in_i.valid |=> !out_valid_q)
    else $error("result transaction repeated");

  a_fid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.byte_valid |-> out_o.field_id <= FID_XDATA)
    else $error("field id out of range");

endmodule
